### rtl/core/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the 3x3 local binary pattern stream.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

   localparam int LBP_MAX_WIDTH     = 1024;
   localparam int LBP_PIX_W         = 8;
   localparam int LBP_CSR_IDX_W     = 2;
   localparam int LBP_CSR_DATA_W    = 12;
   localparam int LBP_FRAME_W_W     = 11;
   localparam int LBP_FRAME_H_W     = 12;
   localparam int LBP_RST_WIDTH     = 640;
   localparam int LBP_RST_HEIGHT    = 480;
   localparam int LBP_MIN_DIM       = 3;

   typedef logic [LBP_PIX_W-1:0] pixel_type;

   typedef enum logic [LBP_CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

endpackage : lbp_pkg

`default_nettype wire

### rtl/core/lbp_3x3_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_stream
// Streaming 3x3 local binary pattern over a raster-order grey frame.
//
//   channel  dir  handshake        payload
//   req      in   valid / stall    pixel_in[7:0]
//   rsp      out  valid / stall    lbp_code[7:0], frame_end
//   csr      in   valid / ready    index[1:0], wdata[11:0]
//
// One word accepted per clock while req does not stall; the pixel that completes
// a window is held in the read stage register alongside the registered line store
// read, and the compare stage then loads the output register that drives rsp.
// Reset clears counters, window and valid flags; line stores stay as they are.
// A stall on rsp holds the output register; req stalls only when the read
// stage cannot drain into it.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_3x3_stream #(
   parameter int MAX_WIDTH = lbp_pkg::LBP_MAX_WIDTH
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire  [lbp_pkg::LBP_PIX_W-1:0]          req_pixel_in,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic [lbp_pkg::LBP_PIX_W-1:0]          rsp_lbp_code,
   output logic                                   rsp_frame_end,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [lbp_pkg::LBP_CSR_IDX_W-1:0]      csr_index,
   input  wire  [lbp_pkg::LBP_CSR_DATA_W-1:0]     csr_wdata
);
   import lbp_pkg::*;

   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WCMP = (CW + 1 > LBP_FRAME_W_W) ? CW + 1 : LBP_FRAME_W_W;
   localparam int HW   = LBP_FRAME_H_W;

   // configuration
   logic [LBP_FRAME_W_W-1:0] width_ff;
   logic [HW-1:0]            height_ff;
   logic [WCMP-1:0]          eff_width;
   logic [HW-1:0]            eff_height;
   logic [CW-1:0]            col_last;
   logic [HW-1:0]            row_last;
   logic                     csr_write;

   // raster position
   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;

   // read stage
   logic          s1_valid_ff, s1_valid_in;
   pixel_type     s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff;
   logic          s1_end_ff;
   logic          s1_adv;
   logic          accept;

   // window: two older columns, index 0 top row
   pixel_type win_ff [2][3];
   pixel_type rd_mid, rd_top;
   pixel_type ctr;
   logic [LBP_PIX_W-1:0] code;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LBP_PIX_W-1:0] rsp_code_ff;
   logic                 rsp_end_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= LBP_FRAME_W_W'(LBP_RST_WIDTH);
         height_ff <= HW'(LBP_RST_HEIGHT);
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[LBP_FRAME_W_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_width = WCMP'(width_ff);
      if (eff_width < WCMP'(LBP_MIN_DIM)) begin
         eff_width = WCMP'(LBP_MIN_DIM);
      end else if (eff_width > WCMP'(MAX_WIDTH)) begin
         eff_width = WCMP'(MAX_WIDTH);
      end
      eff_height = (height_ff < HW'(LBP_MIN_DIM)) ? HW'(LBP_MIN_DIM) : height_ff;
      col_last   = CW'(eff_width - WCMP'(1));
      row_last   = eff_height - HW'(1);
   end

   // handshake
   assign s1_adv    = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + HW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT: begin
               col_in = '0;
               row_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_pixel_in;
         s1_col_ff  <= col_ff;
         s1_emit_ff <= (row_ff >= HW'(2)) && (col_ff >= CW'(2));
         s1_end_ff  <= (row_ff == row_last) && (col_ff == col_last);
      end
   end

   // consecutive words never share a column, so the write-back of one
   // and the read of the next never hit the same entry
   lbp_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_mid  (s1_pix_ff),
      .wr_top  (rd_mid),
      .rd_mid  (rd_mid),
      .rd_top  (rd_top)
   );

   // newest column comes straight from the store and the input register
   always_comb begin
      ctr     = win_ff[1][1];
      code[7] = win_ff[0][0] >= ctr;
      code[6] = win_ff[1][0] >= ctr;
      code[5] = rd_top       >= ctr;
      code[4] = rd_mid       >= ctr;
      code[3] = s1_pix_ff    >= ctr;
      code[2] = win_ff[1][2] >= ctr;
      code[1] = win_ff[0][2] >= ctr;
      code[0] = win_ff[0][1] >= ctr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_adv) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1][0] <= rd_top;
         win_ff[1][1] <= rd_mid;
         win_ff[1][2] <= s1_pix_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         rsp_code_ff <= code;
         rsp_end_ff  <= s1_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lbp_code  = rsp_code_ff;
   assign rsp_frame_end = rsp_end_ff;

   // raster position never runs past the configured frame
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= col_last) && (row_ff <= row_last))
      else $error("raster position beyond frame");

   // store write-back and the next read never address the same column
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_adv) |-> (s1_col_ff != col_ff))
      else $error("line store read and write collide");

   // an emitting word that advances leaves a code in the output register
   a_emit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emit_ff) |=> rsp_valid_ff)
      else $error("code lost between read stage and output");

endmodule : lbp_3x3_stream

`default_nettype wire

### rtl/core/lbp_line_store.sv
// ----------------------------------------------------------------------------
// lbp_line_store
// Two row buffers (previous row and the row before it), one synchronous
// read and one write per cycle each, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_line_store #(
   parameter int DEPTH = lbp_pkg::LBP_MAX_WIDTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                     clock,
   input  wire                     rd_en,
   input  wire  [AW-1:0]           rd_addr,
   input  wire                     wr_en,
   input  wire  [AW-1:0]           wr_addr,
   input  wire  lbp_pkg::pixel_type wr_mid,   // goes to the newer row buffer
   input  wire  lbp_pkg::pixel_type wr_top,   // goes to the older row buffer
   output lbp_pkg::pixel_type      rd_mid,
   output lbp_pkg::pixel_type      rd_top
);
   import lbp_pkg::*;

   pixel_type line_a_mem [DEPTH];
   pixel_type line_b_mem [DEPTH];
   pixel_type rd_mid_ff;
   pixel_type rd_top_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_a_mem[wr_addr] <= wr_mid;
         line_b_mem[wr_addr] <= wr_top;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mid_ff <= line_a_mem[rd_addr];
         rd_top_ff <= line_b_mem[rd_addr];
      end
   end

   assign rd_mid = rd_mid_ff;
   assign rd_top = rd_top_ff;

endmodule : lbp_line_store

`default_nettype wire

### tb/tb_lbp_3x3_stream.sv
// ----------------------------------------------------------------------------
// tb_lbp_3x3_stream
// Self-checking bench for the streaming 3x3 local binary pattern block.
// A short table of hand-built frames checks bit order, equality and the
// minimum size clamps. Random frames of many shapes follow, including restarts
// and ignored register writes. Every random code is compared with an in-bench
// line store and window model while both ports stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lbp_3x3_stream;

   import lbp_pkg::*;

   localparam int RANDOM_ITEMS   = 1530;
   localparam int DRAIN_CYCLES   = 8;
   localparam int STALL_PERCENT  = 17;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_CAP      = 300;

   localparam logic [LBP_CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [LBP_CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic ROW_CSR = 1'b1;
   localparam logic ROW_PIX = 1'b0;

   typedef struct packed {
      pixel_type code;
      logic      frame_end;
   } lbp_result_type;

   typedef struct packed {
      logic                       is_csr;
      logic [LBP_CSR_IDX_W-1:0]   index;
      logic [LBP_CSR_DATA_W-1:0]  wdata;
      pixel_type                  pixel;
      logic                       typed;
      pixel_type                  code;
      logic                       frame_end;
   } step_row_type;

   localparam int DIRECTED_ROWS = 21;

   // 3x3 frames: top-left above the centre, then left equal to the centre
   step_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_CSR, CSR_FRAME_WIDTH,  12'd1,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_CSR, CSR_FRAME_HEIGHT, 12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd255, 1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd128, 1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b1, 8'h80, 1'b1},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd128, 1'b0, 8'h00, 1'b0},
      // unknown index mid-frame must not restart the frame
      '{ROW_CSR, CSR_SPARE_3,      12'hFFF, 8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd128, 1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b0, 8'h00, 1'b0},
      '{ROW_PIX, CSR_FRAME_WIDTH,  12'd0,   8'd0,   1'b1, 8'h01, 1'b1}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   pixel_type                  req_pixel_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   pixel_type                  rsp_lbp_code;
   logic                       rsp_frame_end;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [LBP_CSR_IDX_W-1:0]   csr_index = '0;
   logic [LBP_CSR_DATA_W-1:0]  csr_wdata = '0;

   lbp_3x3_stream uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_lbp_code  (rsp_lbp_code),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---- pattern model state ----
   pixel_type              line_above [LBP_MAX_WIDTH] = '{default: '0};
   pixel_type              line_above2 [LBP_MAX_WIDTH] = '{default: '0};
   pixel_type              window [3][3] = '{default: '{default: '0}};  // [col][row]
   int unsigned            col_pos = 0;
   int unsigned            row_pos = 0;
   logic [LBP_FRAME_W_W-1:0] cfg_width = LBP_FRAME_W_W'(LBP_RST_WIDTH);
   logic [LBP_FRAME_H_W-1:0] cfg_height = LBP_FRAME_H_W'(LBP_RST_HEIGHT);

   lbp_result_type         expected_codes [$];
   int unsigned            error_count = 0;
   int unsigned            random_items = 0;
   bit                     steady_run = 1'b0;
   int unsigned            quiet_cycles = 0;

   function automatic int unsigned used_width();
      if (cfg_width < LBP_MIN_DIM) return LBP_MIN_DIM;
      if (cfg_width > LBP_MAX_WIDTH) return LBP_MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int unsigned used_height();
      return (cfg_height < LBP_MIN_DIM) ? LBP_MIN_DIM : int'(cfg_height);
   endfunction

   function automatic void lbp_advance(input pixel_type pix, output bit got,
                                       output lbp_result_type res);
      int unsigned w;
      int unsigned h;
      pixel_type   top;
      pixel_type   mid;
      pixel_type   ctr;
      w   = used_width();
      h   = used_height();
      top = '0;
      mid = '0;
      got = 1'b0;
      res = '0;
      if (col_pos < LBP_MAX_WIDTH) begin
         top = line_above2[col_pos];
         mid = line_above[col_pos];
         line_above2[col_pos] = mid;
         line_above[col_pos]  = pix;
      end
      window[0] = window[1];
      window[1] = window[2];
      window[2][0] = top;
      window[2][1] = mid;
      window[2][2] = pix;
      if (row_pos >= 2 && col_pos >= 2) begin
         ctr = window[1][1];
         // clockwise from top-left, msb first
         res.code = {window[0][0] >= ctr, window[1][0] >= ctr, window[2][0] >= ctr,
                     window[2][1] >= ctr, window[2][2] >= ctr, window[1][2] >= ctr,
                     window[0][2] >= ctr, window[0][1] >= ctr};
         res.frame_end = (row_pos + 1 >= h) && (col_pos + 1 >= w);
         got = 1'b1;
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic bit roll_idle();
      return !steady_run && ($urandom_range(0, 99) < STALL_PERCENT);
   endfunction

   task automatic drive_pixel(input pixel_type pix, input logic typed,
                              input pixel_type typed_code, input logic typed_end);
      bit             got;
      lbp_result_type res;
      while (roll_idle()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lbp_advance(pix, got, res);
      if (got) begin
         if (typed) begin
            res.code      = typed_code;
            res.frame_end = typed_end;
         end
         expected_codes.push_back(res);
      end
   endtask

   // registers only change with the pipe empty
   task automatic write_csr(input logic [LBP_CSR_IDX_W-1:0] index,
                            input logic [LBP_CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_FRAME_WIDTH) begin
         cfg_width = data[LBP_FRAME_W_W-1:0];
      end else if (index == CSR_FRAME_HEIGHT) begin
         cfg_height = data[LBP_FRAME_H_W-1:0];
      end
      if (index == CSR_FRAME_WIDTH || index == CSR_FRAME_HEIGHT) begin
         col_pos = 0;
         row_pos = 0;
      end
   endtask

   function automatic pixel_type random_pixel(input int unsigned mode);
      case (mode)
         0:       return pixel_type'($urandom_range(0, 3));   // lots of ties
         1:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         default: return pixel_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic pick_setting();
      case ($urandom_range(0, 7))
         0: write_csr(CSR_FRAME_WIDTH, LBP_CSR_DATA_W'($urandom_range(0, 2)));
         1: write_csr(CSR_FRAME_HEIGHT, LBP_CSR_DATA_W'($urandom_range(0, 2)));
         2: write_csr(CSR_FRAME_HEIGHT, 12'd4095);
         3: write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                      LBP_CSR_DATA_W'($urandom));
         4: write_csr(CSR_FRAME_WIDTH, LBP_CSR_DATA_W'($urandom_range(11, 40)));
         default: begin
            write_csr(CSR_FRAME_WIDTH, LBP_CSR_DATA_W'($urandom_range(3, 10)));
            write_csr(CSR_FRAME_HEIGHT, LBP_CSR_DATA_W'($urandom_range(3, 6)));
         end
      endcase
   endtask

   // ---- result side ----
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : roll_idle();
   end

   always @(posedge clock) begin
      lbp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected word, code %h frame_end %b", $time,
                     rsp_lbp_code, rsp_frame_end);
            error_count++;
         end else begin
            want = expected_codes.pop_front();
            if (rsp_lbp_code !== want.code) begin
               $display("%0t: lbp_code expected %h actual %h", $time,
                        want.code, rsp_lbp_code);
               error_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %b actual %b", $time,
                        want.frame_end, rsp_frame_end);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---- stimulus ----
   initial begin
      int unsigned frame_len;
      int unsigned count;
      int unsigned mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            write_csr(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            drive_pixel(directed_rows[i].pixel, directed_rows[i].typed,
                        directed_rows[i].code, directed_rows[i].frame_end);
         end
      end

      while (random_items < RANDOM_ITEMS) begin
         pick_setting();
         frame_len = used_width() * used_height();
         if ($urandom_range(0, 4) == 0) begin
            count = $urandom_range(1, 2 * frame_len);   // cut short, restarts next
         end else begin
            count = frame_len * $urandom_range(1, 2);
         end
         if (count > PHASE_CAP) count = $urandom_range(PHASE_CAP - 100, PHASE_CAP);
         if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
         mode = $urandom_range(0, 2);
         repeat (count) begin
            steady_run = (random_items >= 500 && random_items < 800);
            drive_pixel(random_pixel(mode), 1'b0, '0, 1'b0);
            random_items++;
         end
      end
      steady_run = 1'b0;

      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (4 * DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_codes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_line_store.sv
rtl/core/lbp_3x3_stream.sv
tb/tb_lbp_3x3_stream.sv
